// ----- design/segment_halfspace_intersect_unit_assert.svh -----
// Assertion macros for the segment half-space unit.
`ifndef SEGMENT_HALFSPACE_INTERSECT_UNIT_ASSERT_SVH
`define SEGMENT_HALFSPACE_INTERSECT_UNIT_ASSERT_SVH

// a implies b on the same edge
`define SHI_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// a implies b on the next edge
`define SHI_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

// ----- design/shi_pkg.sv -----
package shi_pkg;
  localparam int DIM = 4;
  localparam int W = 32;
  localparam int FRAC = 16;
  localparam int SW = 52;          // sum width of floored products plus offset
  localparam int MW = 53;          // |sA|+|sB| width
  localparam int DIV_NS = 4;       // divider stages
  localparam int DIV_BPS = FRAC / DIV_NS;
  localparam int LAT = DIV_NS + 4; // products, sum, abs, divider, output
  localparam int IN_TW = 2 * DIM * W;
  localparam int OUT_TW = 3 + DIM * W;
  localparam int OUT_TB = ((OUT_TW + 7) / 8) * 8;

  localparam logic [2:0] CFG_OFFSET = 3'd4;

  typedef logic signed [W-1:0] coord_t;
  typedef coord_t vec_t [DIM];
endpackage

// ----- design/shi_dist.sv -----
// Stages 1-2: floored Q16.16 products, then summed distances.
module shi_dist import shi_pkg::*; (
  input  logic clk,
  input  logic en,
  input  vec_t nrm,
  input  coord_t ofs,
  input  vec_t a,
  input  vec_t b,
  output logic signed [SW-1:0] sa_r,
  output logic signed [SW-1:0] sb_r
);
  logic signed [2*W-FRAC-1:0] pa_r [DIM];
  logic signed [2*W-FRAC-1:0] pb_r [DIM];
  logic signed [SW-1:0] sa_nxt, sb_nxt;
  logic signed [2*W-1:0] ma [DIM];
  logic signed [2*W-1:0] mb [DIM];

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      ma[i] = nrm[i] * a[i];
      mb[i] = nrm[i] * b[i];
    end
    sa_nxt = SW'(ofs);
    sb_nxt = SW'(ofs);
    for (int i = 0; i < DIM; i++) begin
      sa_nxt = sa_nxt + SW'(pa_r[i]);
      sb_nxt = sb_nxt + SW'(pb_r[i]);
    end
  end

  // arithmetic shift floors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIM; i++) begin
        pa_r[i] <= ma[i][2*W-1:FRAC];
        pb_r[i] <= mb[i][2*W-1:FRAC];
      end
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end
endmodule

// ----- design/shi_div.sv -----
// 16-step restoring divide, 4 quotient bits per stage over 4 stages.
module shi_div import shi_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [MW-1:0] na,
  input  logic [MW-1:0] den,
  output logic [FRAC:0] t
);
  logic [MW:0] r_r [DIV_NS];
  logic [MW-1:0] d_r [DIV_NS];
  logic [FRAC-1:0] q_r [DIV_NS];
  logic full_r [DIV_NS];
  logic [MW:0] rn [DIV_NS];
  logic [FRAC-1:0] qn [DIV_NS];

  always_comb begin
    for (int s = 0; s < DIV_NS; s++) begin
      rn[s] = (s == 0) ? {1'b0, na} : r_r[s-1];
      qn[s] = (s == 0) ? '0 : q_r[s-1];
      for (int k = 0; k < DIV_BPS; k++) begin
        rn[s] = {rn[s][MW-1:0], 1'b0};
        qn[s] = {qn[s][FRAC-2:0], 1'b0};
        if (rn[s] >= {1'b0, ((s == 0) ? den : d_r[s-1])}) begin
          rn[s] = rn[s] - {1'b0, ((s == 0) ? den : d_r[s-1])};
          qn[s][0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_NS; s++) begin
        r_r[s] <= rn[s];
        q_r[s] <= qn[s];
        d_r[s] <= (s == 0) ? den : d_r[s-1];
        full_r[s] <= (s == 0) ? (na >= den) : full_r[s-1];
      end
    end
  end

  assign t = full_r[DIV_NS-1] ? (FRAC+1)'(1 << FRAC) : {1'b0, q_r[DIV_NS-1]};
endmodule

// ----- design/segment_halfspace_intersect_unit.sv -----
// Segment against half-space n.x + plane_offset <= 0, Q16.16.
// Input word on in_tdata: a_0..a_3 then b_0..b_3, 32 bits each, lowest first.
// Result word on out_tdata: hit, a_inside, b_inside, p_0..p_3, zero padded.
// Config: cfg_index 0..3 = normal_0..3, 4 = plane_offset; others ignored.
// Write config only while the pipeline is empty.
// Throughput: one word per cycle unless the output stalls. Pipeline: 8 register
// stages (products, sum, sign/abs, four divider stages, interpolation); out_tvalid
// is the last bit of a valid shift register that advances with the stages.
// The pipeline is one enable wide: when out_tready is low and the output
// register is full, every stage holds; in_tready = !out_tvalid | out_tready.
// Reset (rst_n low, synchronous) clears all valid bits and the config registers.
module segment_halfspace_intersect_unit import shi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [IN_TW-1:0] in_tdata,   // a_0, a_1, a_2, a_3, b_0, b_1, b_2, b_3
  output logic out_tvalid,
  input  logic out_tready,
  output logic [OUT_TB-1:0] out_tdata, // hit, a_inside, b_inside, p_0..p_3
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [W-1:0] cfg_data
);
  vec_t nrm_r;
  coord_t ofs_r;
  vec_t a, b;
  logic en;
  logic [LAT-1:0] v_r;
  vec_t a_d [LAT-1];
  vec_t b_d [LAT-1];
  logic signed [SW-1:0] sa, sb;
  logic [MW-1:0] na_r, den_r;
  logic [2:0] fl_r [DIV_NS+1]; // from bit 0: hit, a_in, b_in
  logic [FRAC:0] t;
  logic signed [W-1:0] p_nxt [DIM];
  logic signed [W:0] dd [DIM];
  logic signed [W+FRAC+1:0] pr [DIM];
  logic signed [W+FRAC+1:0] st [DIM];
  logic [OUT_TB-1:0] od_nxt;

  assign cfg_ready = 1'b1;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM; i++) nrm_r[i] <= '0;
      ofs_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index < 3'(DIM)) nrm_r[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == CFG_OFFSET) ofs_r <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      a[i] = in_tdata[i*W +: W];
      b[i] = in_tdata[(DIM+i)*W +: W];
    end
  end

  shi_dist u_dist (.clk(clk), .en(en), .nrm(nrm_r), .ofs(ofs_r), .a(a), .b(b),
                   .sa_r(sa), .sb_r(sb));

  shi_div u_div (.clk(clk), .en(en), .na(na_r), .den(den_r), .t(t));

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_tvalid};
  end

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      dd[i] = (W+1)'(b_d[LAT-2][i]) - (W+1)'(a_d[LAT-2][i]);
      pr[i] = dd[i] * $signed({1'b0, t});
      st[i] = pr[i][W+FRAC+1] ? -((-pr[i]) >>> FRAC) : (pr[i] >>> FRAC);
      p_nxt[i] = fl_r[DIV_NS][0] ? W'(a_d[LAT-2][i] + st[i][W-1:0]) : '0;
    end
    od_nxt = '0;
    od_nxt[2:0] = fl_r[DIV_NS];
    for (int i = 0; i < DIM; i++) od_nxt[3 + i*W +: W] = p_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d[0] <= a;
      b_d[0] <= b;
      for (int s = 1; s < LAT-1; s++) begin
        a_d[s] <= a_d[s-1];
        b_d[s] <= b_d[s-1];
      end
      na_r <= MW'(sa[SW-1] ? -sa : sa);
      den_r <= MW'(sa[SW-1] ? -sa : sa) + MW'(sb[SW-1] ? -sb : sb);
      fl_r[0] <= {sb <= 0, sa <= 0,
                  (sa != sb) && !(sa > 0 && sb > 0) && !(sa < 0 && sb < 0)};
      for (int s = 1; s < DIV_NS+1; s++) fl_r[s] <= fl_r[s-1];
      out_tdata <= od_nxt;
    end
  end
endmodule

// ----- design/shi_checker.sv -----
module shi_checker import shi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OUT_TB-1:0] out_tdata
);
`include "segment_halfspace_intersect_unit_assert.svh"
  `SHI_ASSERT_IMP(a_rdy, clk, rst_n, out_tready, in_tready, "ready must follow sink")
  `SHI_ASSERT_IMP(a_nohit, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[OUT_TW-1:3] == '0, "p nonzero")
  `SHI_ASSERT_IMP(a_hit, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[1] || out_tdata[2], "hit w/o inside")
  `SHI_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stall lost word")
endmodule

bind segment_halfspace_intersect_unit shi_checker u_chk (.*);

// ----- test/testbench.sv -----
module testbench;
  import shi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0][31:0] p;
    logic b_inside;
    logic a_inside;
    logic hit;
  } seg_result_t;

  // Expected result words, oldest first, plus a copy of the half-space registers.
  class intersect_scoreboard;
    seg_result_t pending[$];
    longint normal[4];
    longint offset;
    int errors;

    function void set_reg(int idx, logic [31:0] val);
      if (idx < 4) normal[idx] = longint'($signed(val));
      else if (idx == 4) offset = longint'($signed(val));
    endfunction

    function longint distance(logic [3:0][31:0] x);
      longint acc;
      longint prod;
      acc = offset;
      for (int i = 0; i < DIM; i++) begin
        prod = normal[i] * longint'($signed(x[i]));
        acc += prod >>> 16; // arithmetic shift floors
      end
      return acc;
    endfunction

    function void note_segment(logic [IN_TW-1:0] word);
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      longint sa, sb, na, nb, den, t, d, prod, stepv, rem, q;
      seg_result_t r;
      a = word[127:0];
      b = word[255:128];
      sa = distance(a);
      sb = distance(b);
      r = '0;
      r.hit = (sa != sb) && !(sa > 0 && sb > 0) && !(sa < 0 && sb < 0);
      r.a_inside = sa <= 0;
      r.b_inside = sb <= 0;
      if (r.hit) begin
        na = sa < 0 ? -sa : sa;
        nb = sb < 0 ? -sb : sb;
        den = na + nb;
        if (na >= den) t = 65536;
        else begin
          // long division; na * 2^16 would not fit in 64 bits
          rem = na;
          q = 0;
          for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
              rem -= den;
              q |= 1;
            end
          end
          t = q;
        end
        for (int i = 0; i < DIM; i++) begin
          d = longint'($signed(b[i])) - longint'($signed(a[i]));
          prod = d * t;
          stepv = prod >= 0 ? prod / 65536 : -((-prod) / 65536);
          r.p[i] = 32'(longint'($signed(a[i])) + stepv);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TB-1:0] word);
      seg_result_t got, want;
      got = word[OUT_TW-1:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit)
        $display("%0t: hit expected %b actual %b", $realtime, want.hit, got.hit);
      if (got.a_inside !== want.a_inside)
        $display("%0t: a_inside expected %b actual %b", $realtime, want.a_inside,
                 got.a_inside);
      if (got.b_inside !== want.b_inside)
        $display("%0t: b_inside expected %b actual %b", $realtime, want.b_inside,
                 got.b_inside);
      for (int i = 0; i < DIM; i++)
        if (got.p[i] !== want.p[i])
          $display("%0t: p_%0d expected %h actual %h", $realtime, i, want.p[i], got.p[i]);
      if (got !== want) errors++;
      if (word[OUT_TB-1:OUT_TW] !== '0) begin
        $display("%0t: pad expected 0 actual %h", $realtime, word[OUT_TB-1:OUT_TW]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TB-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  logic sink_on = 1'b1;

  intersect_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_halfspace_intersect_unit u_dut (.*);

  localparam int REG_OFFSET = int'(CFG_OFFSET);
  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return MAXV - $urandom_range(0, 3);
      2: return MINV + $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  task automatic write_reg(int idx, logic [31:0] val);
    cfg_index <= 3'(idx);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_OFFSET) sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // in_tvalid stays high after the accept; the next call with a gap, or drain(), drops it
  task automatic send_segment(logic [IN_TW-1:0] word, bit do_gap);
    int gap;
    gap = do_gap ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_segment(word);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // random segment; half the time a_0 is nonnegative and b_0 nonpositive
  function automatic logic [IN_TW-1:0] straddle();
    logic [3:0][31:0] a, b;
    for (int i = 0; i < 4; i++) begin
      a[i] = rand_coord();
      b[i] = rand_coord();
    end
    if ($urandom_range(0, 1)) begin
      a[0] = 32'($signed($urandom_range(0, 50 << 16)));
      b[0] = 32'(-$signed($urandom_range(0, 50 << 16)));
    end
    return {b, a};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // sink stall pattern: random wait per word, with quiet stretches
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (out_tready && out_tvalid) begin
        w = sink_on ? $urandom_range(0, 12) : 0;
        if (w != 0) begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_tready <= 1'b1;
      end else if (!out_tready) begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [3:0][31:0] a, b;
    logic [31:0] cfg_set[5];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: all zero, every segment parallel
    send_segment({8{32'h00010000}}, 0);
    drain();
    // axis-aligned plane x0 - 1.0 <= 0
    write_reg(0, 32'h00010000);
    write_reg(1, 32'h0);
    write_reg(2, 32'h0);
    write_reg(3, 32'h0);
    write_reg(REG_OFFSET, 32'hffff0000);
    write_reg(5, 32'h12345678); // ignored index
    a = '0; b = '0;
    a[0] = 32'h0; b[0] = 32'h00020000; b[1] = 32'h00040000;
    send_segment({b, a}, 0);                       // crossing
    send_segment({a, b}, 0);                       // reverse crossing
    a[0] = 32'h00010000; send_segment({b, a}, 0);  // A on plane
    send_segment({a, a}, 0);                       // both on plane, parallel
    a[0] = 32'h00030000; send_segment({b, a}, 0);  // both outside
    a[0] = 32'hfff00000; b[0] = 32'h00008000; send_segment({b, a}, 0); // both inside
    send_segment({{4{MAXV}}, {4{MINV}}}, 0);
    send_segment({{4{MINV}}, {4{MAXV}}}, 0);
    send_segment({8{32'hffffffff}}, 0);
    drain();
    write_reg(0, MAXV); write_reg(1, MINV); write_reg(2, MAXV); write_reg(3, MINV);
    write_reg(REG_OFFSET, MAXV);
    send_segment({{4{MAXV}}, {4{MINV}}}, 0);
    send_segment({{2{MINV, MAXV}}, {2{MAXV, MINV}}}, 0);
    send_segment({8{32'h0}}, 0);
    drain();
    write_reg(REG_OFFSET, MINV);
    send_segment({{2{MINV, MAXV}}, {4{32'h0}}}, 0);
    send_segment({{4{32'h0}}, {2{MINV, MAXV}}}, 0);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      for (int i = 0; i < 5; i++)
        cfg_set[i] = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_coord();
      if (ph % 5 == 4) cfg_set[REG_OFFSET] = ph[0] ? MAXV : MINV;
      for (int i = 0; i < 5; i++) write_reg(i, cfg_set[i]);
      sink_on = (ph % 4 != 3);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) != 0) send_segment(straddle(), sink_on);
        else begin
          for (int i = 0; i < 4; i++) begin
            a[i] = rand_coord();
            b[i] = rand_coord();
          end
          if ($urandom_range(0, 9) == 0) b = a;
          send_segment({b, a}, sink_on);
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
